>>> hw/rtl/mh2_pkg.sv
// Shared types, constants and helpers for the MurmurHash2 bucket selector.
// No dependencies; used by the top level, the modulo unit and the checker.
`default_nettype none

package mh2_pkg;

    // Mixing constants of 32-bit MurmurHash2
    localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] HASH_SEED   = 32'd1;

    // Default limits
    localparam int MAX_KEY_LEN_DEF = 1024;
    localparam int MAX_BUCKETS_DEF = 256;

    // Field widths
    localparam int HASH_W  = 32;
    localparam int BIDX_W  = 8;
    localparam int KIDX_W  = 40;
    localparam int KLEN_W  = 11;
    localparam int BKT_W   = 9;
    localparam int OUT_W   = HASH_W + BIDX_W + KIDX_W;

    // Configuration port
    localparam int          CFG_IDX_W   = 2;
    localparam int          CFG_DATA_W  = KLEN_W;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BKT_CNT = 2'd1;

    // Register reset values
    localparam logic [KLEN_W-1:0] KEY_LEN_RST = 11'd32;
    localparam logic [BKT_W-1:0]  BKT_CNT_RST = 9'd1;

    // Request to the modulo unit
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [BKT_W-1:0]  divisor;
    } t_mod_req;

    // Response from the modulo unit
    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] remainder;
    } t_mod_rsp;

    // Zero reads as one, anything above the limit reads as the limit.
    function automatic logic [31:0] sat_range(input logic [31:0] value,
                                              input logic [31:0] limit);
        logic [31:0] res;
        if (value == 32'd0) begin
            res = 32'd1;
        end else if (value > limit) begin
            res = limit;
        end else begin
            res = value;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mh2_mod_unit.sv
// Bit-serial restoring remainder unit: hash modulo bucket count.
// Depends on mh2_pkg for widths and the request and response structs.
`default_nettype none

module mh2_mod_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mh2_pkg::t_mod_req i_req,
    output mh2_pkg::t_mod_rsp      o_rsp
);

    localparam int CNT_W = $clog2(mh2_pkg::HASH_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [mh2_pkg::HASH_W-1:0]  r_dvd;
    logic [mh2_pkg::BKT_W-1:0]   r_rem;
    logic [mh2_pkg::BKT_W-1:0]   r_div;
    logic [mh2_pkg::BKT_W:0]     trial;

    // Bring down the next dividend bit beside the partial remainder
    assign trial = {r_rem, r_dvd[mh2_pkg::HASH_W-1]};

    // One quotient bit per cycle, most significant first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(mh2_pkg::HASH_W);
                r_dvd  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (trial >= {1'b0, r_div}) begin
                    r_rem <= mh2_pkg::BKT_W'(trial - {1'b0, r_div});
                end else begin
                    r_rem <= trial[mh2_pkg::BKT_W-1:0];
                end
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

>>> hw/rtl/murmurhash2_bucket_select.sv
// Top level of the MurmurHash2 bucket selector: byte packing, mixing sequencer
// and output register. Depends on mh2_pkg and mh2_mod_unit.
//
//  Channel  | Direction | Handshake               | Word
//  ---------+-----------+-------------------------+---------------------------------
//  s        | in        | i_s_tvalid / o_s_tready | key_byte [7:0]
//  m        | out       | o_m_tvalid / i_m_tready | hash, bucket, key index (80 bits)
//  cfg      | in        | i_cfg_valid/o_cfg_ready | index [1:0], data [10:0]
//
// A byte that does not complete a 4-byte word is only packed; one that does sends
// the word three times through the single 32-bit multiplier (S_K1, S_K2, S_H).
// After the last byte of a key come tail fold (S_TAIL), avalanche (S_FIN1, S_FIN2),
// the start of the bit-serial modulo unit (S_MODST) and the wait for it (S_MOD); the
// result then enters the output register from S_EMIT.
// Reset is synchronous and active low. A stalled output word holds the sequencer
// only once the next result is ready; bytes are taken meanwhile.
`default_nettype none

module murmurhash2_bucket_select #(
    parameter int MAX_KEY_LEN = mh2_pkg::MAX_KEY_LEN_DEF,
    parameter int MAX_BUCKETS = mh2_pkg::MAX_BUCKETS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // key_byte [7:0]
    input  wire logic [7:0]                     i_s_tdata,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // hash_value [31:0], bucket_index [39:32], key_index [79:40]
    output logic [mh2_pkg::OUT_W-1:0]           o_m_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mh2_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mh2_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LEN_W = $clog2(MAX_KEY_LEN + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_K1    = 4'd1;
    localparam logic [3:0] S_K2    = 4'd2;
    localparam logic [3:0] S_H     = 4'd3;
    localparam logic [3:0] S_TAIL  = 4'd4;
    localparam logic [3:0] S_FIN1  = 4'd5;
    localparam logic [3:0] S_FIN2  = 4'd6;
    localparam logic [3:0] S_MODST = 4'd7;
    localparam logic [3:0] S_MOD   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]                     r_state;
    logic [mh2_pkg::KLEN_W-1:0]     r_key_len;
    logic [mh2_pkg::BKT_W-1:0]      r_bkt_cnt;
    logic [31:0]                    r_hash;
    logic [31:0]                    r_k;
    logic [31:0]                    r_word;
    logic [LEN_W-1:0]               r_pos;
    logic [mh2_pkg::KIDX_W-1:0]     r_kcnt;
    logic                           r_out_valid;
    logic [mh2_pkg::OUT_W-1:0]      r_out_data;

    logic [LEN_W-1:0]               eff_len;
    logic [LEN_W-1:0]               cfg_len_eff;
    logic [mh2_pkg::BKT_W-1:0]      eff_bkt;
    logic [LEN_W-1:0]               pos_inc;
    logic [31:0]                    n_word;
    logic [31:0]                    mul_a;
    logic [31:0]                    mul_p;
    logic                           s_acc;
    logic                           cfg_acc;
    mh2_pkg::t_mod_req              mod_req;
    mh2_pkg::t_mod_rsp              mod_rsp;

    // Effective limits after saturation
    assign eff_len     = LEN_W'(mh2_pkg::sat_range(32'(r_key_len), 32'(MAX_KEY_LEN)));
    assign cfg_len_eff = LEN_W'(mh2_pkg::sat_range(32'(i_cfg_data), 32'(MAX_KEY_LEN)));
    assign eff_bkt     = mh2_pkg::BKT_W'(mh2_pkg::sat_range(32'(r_bkt_cnt),
                                                            32'(MAX_BUCKETS)));

    // Handshakes: configuration takes priority over a byte in the same cycle
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign s_acc       = i_s_tvalid && o_s_tready;

    // Little-endian packing of the incoming byte
    assign pos_inc = r_pos + 1'b1;
    assign n_word  = r_word | (32'(i_s_tdata) << {r_pos[1:0], 3'b000});

    // Operand selection for the shared multiplier
    always_comb begin
        case (r_state)
            S_K1:    mul_a = r_k;
            S_K2:    mul_a = r_k ^ (r_k >> mh2_pkg::MIX_SHIFT);
            S_H:     mul_a = r_hash;
            S_TAIL:  mul_a = r_hash ^ r_word;
            S_FIN1:  mul_a = r_hash ^ (r_hash >> mh2_pkg::FIN_SHIFT_A);
            default: mul_a = r_hash;
        endcase
    end

    // Low 32 bits of the product with the mixing constant
    assign mul_p = mul_a * mh2_pkg::MIX_MUL;

    // Remainder request once the avalanche has settled
    assign mod_req.start    = (r_state == S_MODST);
    assign mod_req.dividend = r_hash;
    assign mod_req.divisor  = eff_bkt;

    mh2_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // Sequencer, hash state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_len   <= mh2_pkg::KEY_LEN_RST;
            r_bkt_cnt   <= mh2_pkg::BKT_CNT_RST;
            r_hash      <= mh2_pkg::HASH_SEED ^ mh2_pkg::sat_range(
                               32'(mh2_pkg::KEY_LEN_RST), 32'(MAX_KEY_LEN));
            r_word      <= '0;
            r_pos       <= '0;
            r_kcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cfg_acc) begin
                        unique case (i_cfg_index)
                            mh2_pkg::REG_KEY_LEN: begin
                                r_key_len <= i_cfg_data;
                                r_hash    <= mh2_pkg::HASH_SEED ^ 32'(cfg_len_eff);
                                r_word    <= '0;
                                r_pos     <= '0;
                            end
                            mh2_pkg::REG_BKT_CNT: begin
                                r_bkt_cnt <= i_cfg_data[mh2_pkg::BKT_W-1:0];
                            end
                            default: begin
                            end
                        endcase
                    end else if (s_acc) begin
                        r_pos <= pos_inc;
                        if (pos_inc[1:0] == 2'b00) begin
                            r_k     <= n_word;
                            r_word  <= '0;
                            r_state <= S_K1;
                        end else begin
                            r_word <= n_word;
                            if (pos_inc >= eff_len) begin
                                r_state <= S_TAIL;
                            end
                        end
                    end
                end
                S_K1: begin
                    r_k     <= mul_p;
                    r_state <= S_K2;
                end
                S_K2: begin
                    r_k     <= mul_p;
                    r_state <= S_H;
                end
                S_H: begin
                    r_hash  <= mul_p ^ r_k;
                    r_state <= (r_pos >= eff_len) ? S_TAIL : S_IDLE;
                end
                S_TAIL: begin
                    // A key whose length is a whole number of words has no tail
                    if (eff_len[1:0] != 2'b00) begin
                        r_hash <= mul_p;
                    end
                    r_state <= S_FIN1;
                end
                S_FIN1: begin
                    r_hash  <= mul_p;
                    r_state <= S_FIN2;
                end
                S_FIN2: begin
                    r_hash  <= r_hash ^ (r_hash >> mh2_pkg::FIN_SHIFT_B);
                    r_state <= S_MODST;
                end
                S_MODST: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (mod_rsp.done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // Load the result once the previous word has gone
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_kcnt,
                                        mod_rsp.remainder[mh2_pkg::BIDX_W-1:0],
                                        r_hash};
                        r_kcnt      <= r_kcnt + 1'b1;
                        r_hash      <= mh2_pkg::HASH_SEED ^ 32'(eff_len);
                        r_word      <= '0;
                        r_pos       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> hw/rtl/mh2_checker.sv
// Port-level checks for the MurmurHash2 bucket selector, bound to the top level.
// Depends on mh2_pkg for widths and register indexes.
`default_nettype none

module mh2_checker #(
    parameter int MAX_BUCKETS = mh2_pkg::MAX_BUCKETS_DEF
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic [mh2_pkg::OUT_W-1:0]      o_m_tdata,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic [mh2_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [mh2_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                        r_seen;
    logic [mh2_pkg::KIDX_W-1:0]  r_last_kidx;
    logic [31:0]                 r_eff_bkt;
    logic                        out_acc;

    assign out_acc = o_m_tvalid && i_m_tready;

    // Track the last key index and the bucket count seen on the ports
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= 1'b0;
            r_eff_bkt <= 32'd1;
        end else begin
            if (out_acc) begin
                r_seen      <= 1'b1;
                r_last_kidx <= o_m_tdata[mh2_pkg::OUT_W-1 -: mh2_pkg::KIDX_W];
            end
            if (i_cfg_valid && o_cfg_ready && i_cfg_index == mh2_pkg::REG_BKT_CNT) begin
                r_eff_bkt <= mh2_pkg::sat_range(32'(i_cfg_data[mh2_pkg::BKT_W-1:0]),
                                                32'(MAX_BUCKETS));
            end
        end
    end

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // Key indexes of successive results count up by one
    a_kidx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen |->
            o_m_tdata[mh2_pkg::OUT_W-1 -: mh2_pkg::KIDX_W] == r_last_kidx + 1'b1)
        else $error("key index skipped or repeated");

    // The bucket lies below the bucket count, checked while that count is at most 256
    a_bucket_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_eff_bkt <= 32'd256 |->
            32'(o_m_tdata[mh2_pkg::HASH_W +: mh2_pkg::BIDX_W]) < r_eff_bkt)
        else $error("bucket index out of range");

    // A byte and a configuration write are never taken together
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_s_tvalid && o_s_tready && i_cfg_valid && o_cfg_ready))
        else $error("byte and configuration accepted in one cycle");

    // Nothing is offered straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result offered after reset");

endmodule

bind murmurhash2_bucket_select mh2_checker #(
    .MAX_BUCKETS (MAX_BUCKETS)
) u_mh2_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

`default_nettype wire
